// ===== design/rob_pkg.sv =====
// Package with shared constants and types of the reorder buffer commit core.
package rob_pkg;
   localparam int unsigned RobDepth    = 32;
   localparam int unsigned RetireWidth = 4;
   localparam int unsigned PhysRegs    = 64;
   localparam int unsigned ArchRegs    = 32;

   typedef enum logic [1:0] {
      ACT_ALLOC  = 2'd0,
      ACT_READY  = 2'd1,
      ACT_BRANCH = 2'd2,
      ACT_COMMIT = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      RES_ALLOC   = 3'd0,
      RES_ACK     = 3'd1,
      RES_ERROR   = 3'd2,
      RES_RETIRE  = 3'd3,
      RES_STORE   = 3'd4,
      RES_RESTORE = 3'd5,
      RES_DONE    = 3'd6
   } result_type;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_RANGE = 2'd1;
   localparam logic [1:0] ERR_NOBR  = 2'd2;
   localparam logic [1:0] ERR_FULL  = 2'd3;

   localparam logic [2:0] KIND_REG    = 3'd0;
   localparam logic [2:0] KIND_LOAD   = 3'd1;
   localparam logic [2:0] KIND_STORE  = 3'd2;
   localparam logic [2:0] KIND_CBR    = 3'd3;
   localparam logic [2:0] KIND_UBR    = 3'd4;

   // Payload of one buffer entry as stored in the entry memory.
   typedef struct packed {
      logic [2:0]  kind;
      logic [4:0]  arch_reg;
      logic [5:0]  new_preg;
      logic [5:0]  old_preg;
      logic [3:0]  sq_tag;
      logic [31:0] time_stamp;
   } entry_type;

   // Branch outcome stored per entry.
   typedef struct packed {
      logic        mispredicted;
      logic [31:0] flush_limit;
   } branch_type;
endpackage

// ===== design/reorder_buffer_commit_core.sv =====
// Top level of the reorder buffer commit core: sequencer, flags and pointers.
// One item at a time; busy stays high from acceptance through the cycle of the last result.
// Allocate is decided in the acceptance cycle; set ready and branch evaluation go through
// a target read, a decision and a result. Commit reads and evaluates the head for each
// retired entry, plus a flush read and evaluation for a mispredicted branch and for each
// flushed entry; every step of the head walk goes through the single read port of the
// entry memory. Results appear at most one per cycle with rsp_valid
// and cannot be stalled by the receiver.
module reorder_buffer_commit_core #(
   parameter int unsigned RETIRE_WIDTH = rob_pkg::RetireWidth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [2:0]  req_entry_kind,
   input  logic [4:0]  req_arch_reg,
   input  logic [5:0]  req_new_preg,
   input  logic [5:0]  req_old_preg,
   input  logic [3:0]  req_sq_tag,
   input  logic [31:0] req_entry_time,
   input  logic [5:0]  req_target_index,
   input  logic        req_mispredicted,
   input  logic [31:0] req_flush_limit,
   output logic        rsp_valid,
   output logic [2:0]  rsp_result_kind,
   output logic [1:0]  rsp_error_code,
   output logic [4:0]  rsp_slot_index,
   output logic [4:0]  rsp_ret_arch_reg,
   output logic [5:0]  rsp_ret_new_preg,
   output logic [5:0]  rsp_freed_alias,
   output logic [3:0]  rsp_ret_sq_tag,
   output logic        rsp_is_full,
   output logic        rsp_last
);
   localparam int unsigned ROB_DEPTH = rob_pkg::RobDepth;
   localparam int unsigned AW = $clog2(ROB_DEPTH);
   localparam int unsigned CW = $clog2(ROB_DEPTH + 1);
   localparam int unsigned RW = $clog2(RETIRE_WIDTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_DECIDE, ST_HREAD, ST_HEVAL, ST_FREAD, ST_FEVAL, ST_DONE
   } state_type;

   state_type            state_ff;
   logic [ROB_DEPTH-1:0] valid_ff, ready_ff;
   logic [AW-1:0]        head_ff, tail_ff, bslot_ff, raddr;
   logic [CW-1:0]        fcnt_ff;
   logic [RW-1:0]        rcnt_ff;
   logic [1:0]           act_ff;
   logic [5:0]           tgt_ff;
   logic                 misp_ff;
   logic [31:0]          flim_ff, btime_ff, blim_ff;
   rob_pkg::entry_type   req_ent, ent_rd;
   rob_pkg::branch_type  br_rd, br_wdata;
   logic                 ent_we, br_we;
   logic [AW-1:0]        tgt_idx;
   logic                 tgt_oor, full_now;
   logic                 rv_ff, rl_ff;
   logic [2:0]           rk_ff;
   logic [1:0]           re_ff;
   logic [AW-1:0]        rs_ff;
   logic [4:0]           ra_ff;
   logic [5:0]           rn_ff, ro_ff;
   logic [3:0]           rsid_ff;
   logic [AW-1:0]        head_nx, tail_nx;

   assign tgt_idx  = tgt_ff[AW-1:0];
   assign tgt_oor  = ({26'd0, tgt_ff} >= 32'(ROB_DEPTH));
   assign tail_nx  = (32'(tail_ff) + 32'd1 == 32'(ROB_DEPTH)) ? '0 : AW'(tail_ff + AW'(1));
   assign full_now = (tail_nx == head_ff);
   assign head_nx  = (32'(head_ff) + 32'd1 == 32'(ROB_DEPTH)) ? '0 : AW'(head_ff + AW'(1));
   assign busy     = (state_ff != ST_IDLE);

   always_comb begin
      req_ent.kind       = req_entry_kind;
      req_ent.arch_reg   = 5'(32'(req_arch_reg) % rob_pkg::ArchRegs);
      req_ent.new_preg   = 6'(32'(req_new_preg) % rob_pkg::PhysRegs);
      req_ent.old_preg   = 6'(32'(req_old_preg) % rob_pkg::PhysRegs);
      req_ent.sq_tag     = req_sq_tag;
      req_ent.time_stamp = req_entry_time;
      ent_we = start && !busy && (req_action == rob_pkg::ACT_ALLOC) && !full_now;
      br_we  = ent_we || (state_ff == ST_DECIDE && act_ff == rob_pkg::ACT_BRANCH
                && !tgt_oor && valid_ff[tgt_idx]
                && (ent_rd.kind == rob_pkg::KIND_CBR || ent_rd.kind == rob_pkg::KIND_UBR));
      br_wdata.mispredicted = ent_we ? 1'b0 : misp_ff;
      br_wdata.flush_limit  = ent_we ? 32'd0 : flim_ff;
      raddr = (state_ff == ST_READ) ? tgt_idx : head_ff;
   end

   rob_entry_mem #(.ROB_DEPTH(ROB_DEPTH)) u_mem (
      .clock     (clock),
      .ent_we    (ent_we),
      .ent_waddr (tail_ff),
      .ent_wdata (req_ent),
      .br_we     (br_we),
      .br_waddr  (ent_we ? tail_ff : tgt_idx),
      .br_wdata  (br_wdata),
      .raddr     (raddr),
      .ent_rdata (ent_rd),
      .br_rdata  (br_rd)
   );

   always_ff @(posedge clock) begin
      rv_ff <= 1'b0; rl_ff <= 1'b0;
      rk_ff <= rob_pkg::RES_ACK; re_ff <= rob_pkg::ERR_NONE; rs_ff <= '0;
      ra_ff <= '0; rn_ff <= '0; ro_ff <= '0; rsid_ff <= '0;
      if (reset) begin
         state_ff <= ST_IDLE; valid_ff <= '0; ready_ff <= '0;
         head_ff <= '0; tail_ff <= '0; rcnt_ff <= '0; fcnt_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  act_ff <= req_action; tgt_ff <= req_target_index;
                  misp_ff <= req_mispredicted; flim_ff <= req_flush_limit;
                  rcnt_ff <= '0;
                  if (req_action == rob_pkg::ACT_ALLOC) begin
                     rv_ff <= 1'b1; rl_ff <= 1'b1;
                     if (full_now) begin
                        rk_ff <= rob_pkg::RES_ERROR; re_ff <= rob_pkg::ERR_FULL;
                     end else begin
                        rk_ff <= rob_pkg::RES_ALLOC; rs_ff <= tail_ff;
                        valid_ff[tail_ff] <= 1'b1; ready_ff[tail_ff] <= 1'b0;
                        tail_ff <= tail_nx;
                     end
                     state_ff <= ST_DONE;
                  end else if (req_action == rob_pkg::ACT_COMMIT) begin
                     state_ff <= ST_HREAD;
                  end else begin
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_READ: state_ff <= ST_DECIDE;
            ST_DECIDE: begin
               rv_ff <= 1'b1; rl_ff <= 1'b1; state_ff <= ST_DONE;
               if (tgt_oor) begin
                  rk_ff <= rob_pkg::RES_ERROR; re_ff <= rob_pkg::ERR_RANGE;
               end else if (act_ff == rob_pkg::ACT_READY) begin
                  rk_ff <= rob_pkg::RES_ACK; rs_ff <= tgt_idx;
                  if (valid_ff[tgt_idx]) ready_ff[tgt_idx] <= 1'b1;
               end else if (br_we) begin
                  rk_ff <= rob_pkg::RES_ACK; rs_ff <= tgt_idx;
                  ready_ff[tgt_idx] <= 1'b1;
               end else begin
                  rk_ff <= rob_pkg::RES_ERROR; re_ff <= rob_pkg::ERR_NOBR;
               end
            end
            ST_HREAD: state_ff <= ST_HEVAL;
            ST_HEVAL: begin
               if (32'(rcnt_ff) >= RETIRE_WIDTH || !valid_ff[head_ff] || !ready_ff[head_ff]
                   || ent_rd.kind > rob_pkg::KIND_UBR) begin
                  rv_ff <= 1'b1; rl_ff <= 1'b1; rk_ff <= rob_pkg::RES_DONE;
                  rs_ff <= head_ff; state_ff <= ST_DONE;
               end else begin
                  rcnt_ff <= RW'(rcnt_ff + RW'(1));
                  valid_ff[head_ff] <= 1'b0; ready_ff[head_ff] <= 1'b0;
                  head_ff <= head_nx;
                  if (ent_rd.kind == rob_pkg::KIND_STORE) begin
                     rv_ff <= 1'b1; rk_ff <= rob_pkg::RES_STORE; rs_ff <= head_ff;
                     rsid_ff <= ent_rd.sq_tag;
                  end else if (ent_rd.kind != rob_pkg::KIND_CBR) begin
                     rv_ff <= 1'b1; rk_ff <= rob_pkg::RES_RETIRE; rs_ff <= head_ff;
                     ra_ff <= ent_rd.arch_reg; rn_ff <= ent_rd.new_preg;
                     ro_ff <= ent_rd.old_preg;
                  end
                  if ((ent_rd.kind == rob_pkg::KIND_CBR || ent_rd.kind == rob_pkg::KIND_UBR)
                      && br_rd.mispredicted) begin
                     bslot_ff <= head_ff; btime_ff <= ent_rd.time_stamp;
                     blim_ff <= br_rd.flush_limit; fcnt_ff <= '0;
                     state_ff <= ST_FREAD;
                  end else begin
                     state_ff <= ST_HREAD;
                  end
               end
            end
            ST_FREAD: state_ff <= ST_FEVAL;
            ST_FEVAL: begin
               if (blim_ff != 32'd0 && 32'(fcnt_ff) < ROB_DEPTH && valid_ff[head_ff]
                   && ent_rd.time_stamp >= btime_ff && ent_rd.time_stamp <= blim_ff) begin
                  valid_ff[head_ff] <= 1'b0; ready_ff[head_ff] <= 1'b0;
                  head_ff <= head_nx; fcnt_ff <= CW'(fcnt_ff + CW'(1));
                  state_ff <= ST_FREAD;
               end else begin
                  rv_ff <= 1'b1; rk_ff <= rob_pkg::RES_RESTORE; rs_ff <= bslot_ff;
                  state_ff <= ST_HREAD;
               end
            end
            ST_DONE: state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rv_ff && !reset;
   assign rsp_result_kind   = rk_ff;
   assign rsp_error_code    = re_ff;
   assign rsp_slot_index    = 5'(rs_ff);
   assign rsp_ret_arch_reg  = ra_ff;
   assign rsp_ret_new_preg  = rn_ff;
   assign rsp_freed_alias   = ro_ff;
   assign rsp_ret_sq_tag    = rsid_ff;
   assign rsp_is_full       = full_now;
   assign rsp_last          = rl_ff;
endmodule

// ===== design/rob_entry_mem.sv =====
// Synchronous entry memories with one write port and one registered read port.
module rob_entry_mem #(
   parameter int unsigned ROB_DEPTH = rob_pkg::RobDepth,
   localparam int unsigned AW = $clog2(ROB_DEPTH)
) (
   input  logic                 clock,
   input  logic                 ent_we,
   input  logic [AW-1:0]        ent_waddr,
   input  rob_pkg::entry_type   ent_wdata,
   input  logic                 br_we,
   input  logic [AW-1:0]        br_waddr,
   input  rob_pkg::branch_type  br_wdata,
   input  logic [AW-1:0]        raddr,
   output rob_pkg::entry_type   ent_rdata,
   output rob_pkg::branch_type  br_rdata
);
   rob_pkg::entry_type  ent_mem [ROB_DEPTH];
   rob_pkg::branch_type br_mem  [ROB_DEPTH];
   rob_pkg::entry_type  ent_rd_ff;
   rob_pkg::branch_type br_rd_ff;

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_waddr] <= ent_wdata;
      end
      if (br_we) begin
         br_mem[br_waddr] <= br_wdata;
      end
      ent_rd_ff <= ent_mem[raddr];
      br_rd_ff  <= br_mem[raddr];
   end

   assign ent_rdata = ent_rd_ff;
   assign br_rdata  = br_rd_ff;
endmodule

// ===== verif/reorder_buffer_commit_core_tb.sv =====
// Self-checking testbench of the reorder buffer commit core with a live predictor.
`timescale 1ns / 100ps

module reorder_buffer_commit_core_tb;
   typedef struct {
      rob_pkg::action_type action;
      logic [2:0]  entry_kind;
      logic [4:0]  arch_reg;
      logic [5:0]  new_preg;
      logic [5:0]  old_preg;
      logic [3:0]  sq_tag;
      logic [31:0] entry_time;
      logic [5:0]  target_index;
      logic        mispredicted;
      logic [31:0] flush_limit;
   } rob_op_type;

   typedef struct {
      rob_pkg::result_type kind;
      logic [1:0]  err;
      logic [4:0]  slot;
      logic [4:0]  reg_idx;
      logic [5:0]  nal;
      logic [5:0]  fal;
      logic [3:0]  sid;
      logic        full;
      logic        last;
   } rob_res_type;

   localparam int TotalOps = 320;
   localparam int CycleLimit = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_action = '0;
   logic [2:0]  req_entry_kind = '0;
   logic [4:0]  req_arch_reg = '0;
   logic [5:0]  req_new_preg = '0;
   logic [5:0]  req_old_preg = '0;
   logic [3:0]  req_sq_tag = '0;
   logic [31:0] req_entry_time = '0;
   logic [5:0]  req_target_index = '0;
   logic        req_mispredicted = 1'b0;
   logic [31:0] req_flush_limit = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_result_kind;
   logic [1:0]  rsp_error_code;
   logic [4:0]  rsp_slot_index;
   logic [4:0]  rsp_ret_arch_reg;
   logic [5:0]  rsp_ret_new_preg;
   logic [5:0]  rsp_freed_alias;
   logic [3:0]  rsp_ret_sq_tag;
   logic        rsp_is_full;
   logic        rsp_last;

   reorder_buffer_commit_core u_dut (.*);

   always #4 clock = ~clock;

   rob_op_type  pending_ops[$];
   rob_res_type expected_results[$];
   int       ops_accepted = 0;
   int       failures = 0;
   int       cycle_count = 0;
   logic [31:0] time_base = 32'd100;

   logic        rob_valid[rob_pkg::RobDepth];
   logic        rob_ready[rob_pkg::RobDepth];
   logic [2:0]  rob_kind[rob_pkg::RobDepth];
   logic [4:0]  rob_reg[rob_pkg::RobDepth];
   logic [5:0]  rob_nal[rob_pkg::RobDepth];
   logic [5:0]  rob_oal[rob_pkg::RobDepth];
   logic [3:0]  rob_sid[rob_pkg::RobDepth];
   logic        rob_misp[rob_pkg::RobDepth];
   logic [31:0] rob_time[rob_pkg::RobDepth];
   logic [31:0] rob_limit[rob_pkg::RobDepth];
   logic [4:0]  head_slot = '0;
   logic [4:0]  tail_slot = '0;

   initial begin
      for (int i = 0; i < rob_pkg::RobDepth; i++) begin
         rob_valid[i] = 1'b0;
         rob_ready[i] = 1'b0;
      end
   end

   function automatic rob_res_type make_res(rob_pkg::result_type k, logic [1:0] e,
                                            logic [4:0] s);
      rob_res_type r;
      r = '{k, e, s, 5'd0, 6'd0, 6'd0, 4'd0, 1'b0, 1'b0};
      return r;
   endfunction

   function automatic void retire_head();
      rob_valid[head_slot] = 1'b0;
      rob_ready[head_slot] = 1'b0;
      head_slot = head_slot + 5'd1;
   endfunction

   function automatic void predict_rob(rob_op_type op);
      rob_res_type outs[$];
      rob_res_type r;
      logic [4:0] h;
      logic [4:0] tgt;
      logic [31:0] btime;
      logic [31:0] lim;
      tgt = op.target_index[4:0];
      case (op.action)
         rob_pkg::ACT_ALLOC: begin
            if (tail_slot + 5'd1 == head_slot) begin
               outs.push_back(make_res(rob_pkg::RES_ERROR, rob_pkg::ERR_FULL, 5'd0));
            end else begin
               rob_valid[tail_slot] = 1'b1;
               rob_ready[tail_slot] = 1'b0;
               rob_kind[tail_slot] = op.entry_kind;
               rob_reg[tail_slot] = op.arch_reg;
               rob_nal[tail_slot] = op.new_preg;
               rob_oal[tail_slot] = op.old_preg;
               rob_sid[tail_slot] = op.sq_tag;
               rob_misp[tail_slot] = 1'b0;
               rob_time[tail_slot] = op.entry_time;
               rob_limit[tail_slot] = '0;
               outs.push_back(make_res(rob_pkg::RES_ALLOC, rob_pkg::ERR_NONE, tail_slot));
               tail_slot = tail_slot + 5'd1;
            end
         end
         rob_pkg::ACT_READY: begin
            if (op.target_index >= rob_pkg::RobDepth) begin
               outs.push_back(make_res(rob_pkg::RES_ERROR, rob_pkg::ERR_RANGE, 5'd0));
            end else begin
               if (rob_valid[tgt]) rob_ready[tgt] = 1'b1;
               outs.push_back(make_res(rob_pkg::RES_ACK, rob_pkg::ERR_NONE, tgt));
            end
         end
         rob_pkg::ACT_BRANCH: begin
            if (op.target_index >= rob_pkg::RobDepth) begin
               outs.push_back(make_res(rob_pkg::RES_ERROR, rob_pkg::ERR_RANGE, 5'd0));
            end else if (!rob_valid[tgt] || (rob_kind[tgt] != rob_pkg::KIND_CBR &&
                                             rob_kind[tgt] != rob_pkg::KIND_UBR)) begin
               outs.push_back(make_res(rob_pkg::RES_ERROR, rob_pkg::ERR_NOBR, 5'd0));
            end else begin
               rob_ready[tgt] = 1'b1;
               rob_misp[tgt] = op.mispredicted;
               rob_limit[tgt] = op.flush_limit;
               outs.push_back(make_res(rob_pkg::RES_ACK, rob_pkg::ERR_NONE, tgt));
            end
         end
         default: begin
            for (int i = 0; i < rob_pkg::RetireWidth; i++) begin
               h = head_slot;
               if (!rob_valid[h] || !rob_ready[h] || rob_kind[h] > rob_pkg::KIND_UBR) break;
               if (rob_kind[h] == rob_pkg::KIND_REG || rob_kind[h] == rob_pkg::KIND_LOAD ||
                   rob_kind[h] == rob_pkg::KIND_UBR) begin
                  r = make_res(rob_pkg::RES_RETIRE, rob_pkg::ERR_NONE, h);
                  r.reg_idx = rob_reg[h];
                  r.nal = rob_nal[h];
                  r.fal = rob_oal[h];
                  outs.push_back(r);
               end
               if (rob_kind[h] == rob_pkg::KIND_STORE) begin
                  r = make_res(rob_pkg::RES_STORE, rob_pkg::ERR_NONE, h);
                  r.sid = rob_sid[h];
                  outs.push_back(r);
               end
               if ((rob_kind[h] == rob_pkg::KIND_CBR || rob_kind[h] == rob_pkg::KIND_UBR)
                   && rob_misp[h]) begin
                  btime = rob_time[h];
                  lim = rob_limit[h];
                  retire_head();
                  if (lim != 0) begin
                     for (int g = 0; g < rob_pkg::RobDepth; g++) begin
                        if (!rob_valid[head_slot] || rob_time[head_slot] < btime ||
                            rob_time[head_slot] > lim) break;
                        retire_head();
                     end
                  end
                  outs.push_back(make_res(rob_pkg::RES_RESTORE, rob_pkg::ERR_NONE, h));
               end else begin
                  retire_head();
               end
            end
            outs.push_back(make_res(rob_pkg::RES_DONE, rob_pkg::ERR_NONE, head_slot));
         end
      endcase
      foreach (outs[k]) begin
         outs[k].full = (tail_slot + 5'd1 == head_slot);
         outs[k].last = (k == outs.size() - 1);
         expected_results.push_back(outs[k]);
      end
   endfunction

   function automatic int sender_idle_pct();
      if (ops_accepted < TotalOps / 3) return 24;
      if (ops_accepted < 2 * TotalOps / 3) return 76;
      return 0;
   endfunction

   always @(posedge clock) begin
      rob_op_type op;
      logic    accepted;
      accepted = start && !busy && !reset;
      if (accepted) begin
         op.action = rob_pkg::action_type'(req_action);
         op.entry_kind = req_entry_kind;
         op.arch_reg = req_arch_reg;
         op.new_preg = req_new_preg;
         op.old_preg = req_old_preg;
         op.sq_tag = req_sq_tag;
         op.entry_time = req_entry_time;
         op.target_index = req_target_index;
         op.mispredicted = req_mispredicted;
         op.flush_limit = req_flush_limit;
         predict_rob(op);
         ops_accepted++;
      end
      if (reset) begin
         start <= 1'b0;
      end else if (!start || accepted) begin
         if (pending_ops.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
            op = pending_ops.pop_front();
            req_action <= op.action;
            req_entry_kind <= op.entry_kind;
            req_arch_reg <= op.arch_reg;
            req_new_preg <= op.new_preg;
            req_old_preg <= op.old_preg;
            req_sq_tag <= op.sq_tag;
            req_entry_time <= op.entry_time;
            req_target_index <= op.target_index;
            req_mispredicted <= op.mispredicted;
            req_flush_limit <= op.flush_limit;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rob_res_type e;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result of kind %0d", rsp_result_kind);
            failures++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_result_kind !== e.kind) begin
               $error("result_kind: expected %0d, actual %0d", e.kind, rsp_result_kind);
               failures++;
            end
            if (rsp_error_code !== e.err) begin
               $error("error_code: expected %0d, actual %0d", e.err, rsp_error_code);
               failures++;
            end
            if (rsp_slot_index !== e.slot) begin
               $error("slot_index: expected %0d, actual %0d", e.slot, rsp_slot_index);
               failures++;
            end
            if (rsp_ret_arch_reg !== e.reg_idx) begin
               $error("ret_arch_reg: expected %0d, actual %0d", e.reg_idx, rsp_ret_arch_reg);
               failures++;
            end
            if (rsp_ret_new_preg !== e.nal) begin
               $error("ret_new_preg: expected %0d, actual %0d", e.nal, rsp_ret_new_preg);
               failures++;
            end
            if (rsp_freed_alias !== e.fal) begin
               $error("freed_alias: expected %0d, actual %0d", e.fal, rsp_freed_alias);
               failures++;
            end
            if (rsp_ret_sq_tag !== e.sid) begin
               $error("ret_sq_tag: expected %0d, actual %0d", e.sid, rsp_ret_sq_tag);
               failures++;
            end
            if (rsp_is_full !== e.full) begin
               $error("is_full: expected %0d, actual %0d", e.full, rsp_is_full);
               failures++;
            end
            if (rsp_last !== e.last) begin
               $error("last: expected %0d, actual %0d", e.last, rsp_last);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic rob_op_type make_op(rob_pkg::action_type a, logic [2:0] k,
                                          logic [5:0] tgt);
      rob_op_type op;
      op.action = a;
      op.entry_kind = k;
      op.arch_reg = 5'($urandom);
      op.new_preg = 6'($urandom);
      op.old_preg = 6'($urandom);
      op.sq_tag = 4'($urandom);
      op.entry_time = time_base;
      op.target_index = tgt;
      op.mispredicted = 1'($urandom);
      op.flush_limit = time_base + $urandom_range(40);
      return op;
   endfunction

   function automatic logic [5:0] pick_target();
      logic [5:0] cand;
      if ($urandom_range(99) < 15) return 6'($urandom);
      for (int t = 0; t < 8; t++) begin
         cand = 6'($urandom_range(rob_pkg::RobDepth - 1));
         if (rob_valid[cand[4:0]]) return cand;
      end
      return {1'b0, head_slot};
   endfunction

   initial begin
      rob_op_type op;
      int      sel;
      int      alloc_bias;
      pending_ops.push_back(make_op(rob_pkg::ACT_COMMIT, rob_pkg::KIND_REG, 6'd0));
      pending_ops.push_back(make_op(rob_pkg::ACT_READY, rob_pkg::KIND_REG, 6'd63));
      pending_ops.push_back(make_op(rob_pkg::ACT_BRANCH, rob_pkg::KIND_REG, 6'd32));
      pending_ops.push_back(make_op(rob_pkg::ACT_BRANCH, rob_pkg::KIND_REG, 6'd0));
      pending_ops.push_back(make_op(rob_pkg::ACT_READY, rob_pkg::KIND_REG, 6'd5));
      for (int k = 0; k <= rob_pkg::KIND_UBR; k++) begin
         op = make_op(rob_pkg::ACT_ALLOC, 3'(k), 6'd0);
         op.arch_reg = (k % 2) ? 5'd31 : 5'd0;
         op.new_preg = (k % 2) ? 6'd63 : 6'd0;
         op.old_preg = (k % 2) ? 6'd0 : 6'd63;
         op.sq_tag = (k % 2) ? 4'd15 : 4'd0;
         op.entry_time = (k == 0) ? 32'd0 : 32'd100 + k;
         pending_ops.push_back(op);
      end
      pending_ops.push_back(make_op(rob_pkg::ACT_BRANCH, rob_pkg::KIND_REG, 6'd0));
      for (int s = 0; s < 3; s++) begin
         pending_ops.push_back(make_op(rob_pkg::ACT_READY, rob_pkg::KIND_REG, 6'(s)));
      end
      op = make_op(rob_pkg::ACT_BRANCH, rob_pkg::KIND_REG, 6'd3);
      op.mispredicted = 1'b0;
      op.flush_limit = 32'hFFFF_FFFF;
      pending_ops.push_back(op);
      op = make_op(rob_pkg::ACT_BRANCH, rob_pkg::KIND_REG, 6'd4);
      op.mispredicted = 1'b1;
      op.flush_limit = 32'd0;
      pending_ops.push_back(op);
      op = make_op(rob_pkg::ACT_ALLOC, rob_pkg::KIND_REG, 6'd0);
      op.entry_time = 32'hFFFF_FFFF;
      pending_ops.push_back(op);
      pending_ops.push_back(make_op(rob_pkg::ACT_COMMIT, rob_pkg::KIND_REG, 6'd0));
      pending_ops.push_back(make_op(rob_pkg::ACT_COMMIT, rob_pkg::KIND_REG, 6'd0));
      pending_ops.push_back(make_op(rob_pkg::ACT_COMMIT, rob_pkg::KIND_REG, 6'd0));
      time_base = 32'd1000;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      alloc_bias = 40;
      for (int n = 0; n < TotalOps - 21; n++) begin
         while (pending_ops.size() > 0) @(posedge clock);
         if (n % 60 == 0) alloc_bias = (n % 120 == 0) ? 80 : 35;
         time_base = time_base + $urandom_range(3);
         sel = $urandom_range(99);
         if (sel < alloc_bias) begin
            op = make_op(rob_pkg::ACT_ALLOC, 3'($urandom_range(rob_pkg::KIND_UBR)), 6'd0);
            if ($urandom_range(99) < 5) op.entry_time = 32'($urandom);
         end else if (sel < alloc_bias + 25) begin
            op = make_op(rob_pkg::ACT_READY, rob_pkg::KIND_REG, pick_target());
         end else if (sel < alloc_bias + 40) begin
            op = make_op(rob_pkg::ACT_BRANCH, rob_pkg::KIND_REG, pick_target());
            if (op.target_index < rob_pkg::RobDepth) begin
               op.flush_limit = rob_time[op.target_index[4:0]] + $urandom_range(30);
               case ($urandom_range(9))
                  0: op.flush_limit = 32'd0;
                  1: op.flush_limit = 32'hFFFF_FFFF;
                  2: op.flush_limit = 32'($urandom);
                  default: ;
               endcase
            end
         end else begin
            op = make_op(rob_pkg::ACT_COMMIT, rob_pkg::KIND_REG, 6'd0);
         end
         pending_ops.push_back(op);
      end

      while (pending_ops.size() > 0 || start || busy || expected_results.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0 && expected_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
design/rob_pkg.sv
design/rob_entry_mem.sv
design/reorder_buffer_commit_core.sv
verif/reorder_buffer_commit_core_tb.sv
